[rtl/core/ufold_pkg.sv]
`timescale 1ns / 1ps
// ufold_pkg: shared types, constants and the accent fold table for the
// utf-8 accent folding normalizer; no dependencies
package ufold_pkg;

  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] SPACE_CHAR  = 8'h20;
  localparam logic [7:0] CONT_LO     = 8'h80;
  localparam logic [7:0] CONT_HI     = 8'hBF;
  localparam logic [7:0] LEAD_LO     = 8'hC3;
  localparam logic [7:0] LEAD_HI     = 8'hC5;
  localparam logic [7:0] LEAD_BASE   = 8'hC2;
  localparam logic [7:0] CASE_OFS    = 8'h20;

  localparam logic [1:0] LEAD_NONE = 2'd0;
  localparam logic [1:0] LEAD_C3   = 2'd1;
  localparam logic [1:0] LEAD_C4   = 2'd2;
  localparam logic [1:0] LEAD_C5   = 2'd3;

  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_C = 8'h63;
  localparam logic [7:0] CH_E = 8'h65;
  localparam logic [7:0] CH_G = 8'h67;
  localparam logic [7:0] CH_I = 8'h69;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_O = 8'h6F;
  localparam logic [7:0] CH_S = 8'h73;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_0 = 8'h00;

  // lead c3 fold, indexed by low five bits of the continuation byte
  localparam logic [7:0] FOLD_C3 [32] = '{
    CH_A, CH_A, CH_A, CH_A, CH_A, CH_A, CH_0, CH_C,
    CH_E, CH_E, CH_E, CH_E, CH_I, CH_I, CH_I, CH_I,
    CH_0, CH_N, CH_O, CH_O, CH_O, CH_O, CH_O, CH_0,
    CH_0, CH_U, CH_U, CH_U, CH_U, CH_0, CH_0, CH_0
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       str_end;
    logic       run_last;
  } res_t;

  // zero means no match
  function automatic logic [7:0] fold_pair(input logic [1:0] lead, input logic [7:0] b);
    logic [5:0] off;
    logic [7:0] r;
    off = b[5:0];
    r   = CH_0;
    if (b >= CONT_LO && b <= CONT_HI) begin
      case (lead)
        LEAD_C3: r = FOLD_C3[off[4:0]];
        LEAD_C4: begin
          if (off inside {6'h30, 6'h31}) r = CH_I;
          else if (off inside {6'h1E, 6'h1F}) r = CH_G;
        end
        LEAD_C5: begin
          if (off inside {6'h1E, 6'h1F}) r = CH_S;
        end
        default: r = CH_0;
      endcase
    end
    return r;
  endfunction

endpackage

[rtl/core/utf8_accent_fold_normalizer.sv]
`timescale 1ns / 1ps
// utf8_accent_fold_normalizer: byte stream text normalizer with accent folding
// the first result is registered and presented in the cycle after the input transaction
// throughput: one byte per cycle while each byte gives at most one result and out_ready is high;
// a byte that gives a space and a letter holds the input until the space has been taken
// reset: synchronous active-low rst_n clears the fold state and the result buffer
// depends on ufold_pkg
module utf8_accent_fold_normalizer
  import ufold_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_string_end,
  output logic       out_run_last
);

  logic [1:0] held_r, held_nxt;
  logic       sp_r, sp_nxt;
  logic       os_r, os_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  res_t       slot0_r, slot0_nxt;
  res_t       slot1_r, slot1_nxt;

  logic       in_fire, out_fire;
  logic [7:0] fold_ch, letter, ascii_lc;
  logic       matched, is_lead, has_letter, sp_eff, emit_space;
  logic [1:0] n_res;
  res_t       res0, res1;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);

  always_comb begin
    fold_ch  = fold_pair(held_r, in_byte);
    matched  = (held_r != LEAD_NONE) && (fold_ch != CH_0);
    ascii_lc = CH_0;
    if (in_byte < ASCII_LIMIT) begin
      if (in_byte inside {[8'h41:8'h5A]}) ascii_lc = in_byte + CASE_OFS;
      else if (in_byte inside {[8'h61:8'h7A], [8'h30:8'h39]}) ascii_lc = in_byte;
    end
    letter     = matched ? fold_ch : ascii_lc;
    has_letter = (letter != CH_0);
    is_lead    = !matched && !has_letter && in_byte >= LEAD_LO && in_byte <= LEAD_HI
                 && !in_last_byte;
    // separator sources: unmatched held lead, or a plain separator byte
    sp_eff = sp_r;
    if (held_r != LEAD_NONE && !matched) sp_eff = os_r;
    if (!matched && !has_letter && !is_lead) sp_eff = os_r;
    emit_space = has_letter && sp_eff && os_r;

    res0  = '0;
    res1  = '0;
    n_res = 2'd0;
    if (emit_space) begin
      res0  = '{ch: SPACE_CHAR, valid: 1'b1, str_end: 1'b0, run_last: 1'b0};
      res1  = '{ch: letter, valid: 1'b1, str_end: in_last_byte, run_last: 1'b1};
      n_res = 2'd2;
    end else if (has_letter) begin
      res0  = '{ch: letter, valid: 1'b1, str_end: in_last_byte, run_last: 1'b1};
      n_res = 2'd1;
    end else if (in_last_byte) begin
      res0  = '{ch: CH_0, valid: 1'b0, str_end: 1'b1, run_last: 1'b1};
      n_res = 2'd1;
    end

    if (in_last_byte) begin
      held_nxt = LEAD_NONE;
      sp_nxt   = 1'b0;
      os_nxt   = 1'b0;
    end else begin
      held_nxt = is_lead ? 2'(in_byte - LEAD_BASE) : LEAD_NONE;
      sp_nxt   = has_letter ? 1'b0 : sp_eff;
      os_nxt   = os_r || has_letter;
    end
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (in_fire) begin
      cnt_nxt   = n_res;
      slot0_nxt = res0;
      slot1_nxt = res1;
    end else if (out_fire) begin
      cnt_nxt   = cnt_r - 2'd1;
      slot0_nxt = slot1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= LEAD_NONE;
      sp_r   <= 1'b0;
      os_r   <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_fire) begin
        held_r <= held_nxt;
        sp_r   <= sp_nxt;
        os_r   <= os_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_valid      = (cnt_r != 2'd0);
  assign out_byte       = slot0_r.ch;
  assign out_byte_valid = slot0_r.valid;
  assign out_string_end = slot0_r.str_end;
  assign out_run_last   = slot0_r.run_last;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("result buffer count out of range");
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> cnt_r != 2'd2) else $error("transaction accepted with full buffer");
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_string_end |-> out_run_last) else $error("string end not run last");
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last_byte |=> held_r == LEAD_NONE && !os_r && !sp_r)
    else $error("state not cleared at string end");
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last_byte |=> out_valid) else $error("no result for last byte");
`endif

endmodule
